// ----- rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the postfix expression evaluator
// Stack geometry, character codes, status codes, fixed-point limits and the
// microcode program of the control sequencer.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int SYM_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

    localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

    // Number of restoring divider iterations, one quotient bit each.
    localparam int DIV_STEPS = 32;
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_SAT   = 3'd4,
        ST_EMPTY = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_WAIT, S_CLASS, S_ISOP, S_POPR, S_POPL, S_LOADL, S_ISMUL, S_ADD,
        S_MULP, S_MULF, S_DIVC, S_DIVI, S_DIVF, S_PUSH, S_LAST, S_EMIT
    } t_step;

    typedef enum logic [3:0] {
        ACT_FETCH, ACT_NONE, ACT_POPR, ACT_POPL, ACT_LOADL, ACT_ADDSUB,
        ACT_MULP, ACT_MULF, ACT_DIVCHK, ACT_DIVSTEP, ACT_DIVFIN, ACT_PUSH,
        ACT_RDTOP, ACT_EMIT
    } t_act;

    typedef enum logic [3:0] {
        C_ALWAYS, C_ACCEPT, C_DIGIT, C_OPER, C_DIV, C_MUL, C_DIVSKIP,
        C_DIVLAST, C_LAST, C_OUTFREE
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step nxt_t;
        t_step nxt_f;
    } t_uop;

    // Control store: one control word per step; the condition selects
    // between the two successors.
    function automatic t_uop pfe_ucode(input t_step step);
        t_uop u;
        unique case (step)
            S_WAIT:  u = '{ACT_FETCH,   C_ACCEPT,  S_CLASS, S_WAIT};
            S_CLASS: u = '{ACT_NONE,    C_DIGIT,   S_PUSH,  S_ISOP};
            S_ISOP:  u = '{ACT_NONE,    C_OPER,    S_POPR,  S_LAST};
            S_POPR:  u = '{ACT_POPR,    C_ALWAYS,  S_POPL,  S_POPL};
            S_POPL:  u = '{ACT_POPL,    C_ALWAYS,  S_LOADL, S_LOADL};
            S_LOADL: u = '{ACT_LOADL,   C_DIV,     S_DIVC,  S_ISMUL};
            S_ISMUL: u = '{ACT_NONE,    C_MUL,     S_MULP,  S_ADD};
            S_ADD:   u = '{ACT_ADDSUB,  C_ALWAYS,  S_PUSH,  S_PUSH};
            S_MULP:  u = '{ACT_MULP,    C_ALWAYS,  S_MULF,  S_MULF};
            S_MULF:  u = '{ACT_MULF,    C_ALWAYS,  S_PUSH,  S_PUSH};
            S_DIVC:  u = '{ACT_DIVCHK,  C_DIVSKIP, S_PUSH,  S_DIVI};
            S_DIVI:  u = '{ACT_DIVSTEP, C_DIVLAST, S_DIVF,  S_DIVI};
            S_DIVF:  u = '{ACT_DIVFIN,  C_ALWAYS,  S_PUSH,  S_PUSH};
            S_PUSH:  u = '{ACT_PUSH,    C_ALWAYS,  S_LAST,  S_LAST};
            S_LAST:  u = '{ACT_RDTOP,   C_LAST,    S_EMIT,  S_WAIT};
            S_EMIT:  u = '{ACT_EMIT,    C_OUTFREE, S_WAIT,  S_EMIT};
            default: u = '{ACT_NONE,    C_ALWAYS,  S_WAIT,  S_WAIT};
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/pfe_if.sv -----
// ----------------------------------------------------------------------------
// pfe_if: valid/ready channels of the postfix expression evaluator
// pfe_sym_if carries one character item, pfe_res_if one result item.
// ----------------------------------------------------------------------------
interface pfe_sym_if;
    logic                         valid;
    logic                         ready;
    logic [pfe_pkg::SYM_W-1:0]    symbol;
    logic                         is_last;

    modport source (output valid, output symbol, output is_last, input ready);
    modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface pfe_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [pfe_pkg::VALUE_W-1:0]  result_value;
    logic [pfe_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- rtl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: stack evaluator for postfix expressions
// The block takes one ASCII character per item on i_sym. A digit pushes its
// value as signed Q16.16; + - * / pop the right and then the left operand and
// push the result, saturating on overflow; other characters are ignored. On
// the item marked is_last a result item (top of stack and the first error of
// the expression) is placed in the output register and the stack is cleared.
// A microcoded sequencer steps one item through a single datapath, so the
// block takes no new character until it is through with the last one. A
// divide runs the 32-iteration restoring divider, which is skipped when the
// divisor is zero or the quotient overflows; emitting a result waits while
// the output side stalls a previous result. The stack is a 16-entry memory
// with one registered read port.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfe_sym_if.sink    i_sym,
    pfe_res_if.source  o_res
);
    import pfe_pkg::*;

    t_step r_step, n_step;
    t_uop  w_uop;
    logic  w_cond;

    logic [SYM_W-1:0]          r_sym, n_sym;
    logic                      r_last, n_last;
    logic signed [VALUE_W-1:0] r_res, n_res;
    logic signed [VALUE_W-1:0] r_a, n_a;
    logic signed [VALUE_W-1:0] r_b, n_b;
    logic signed [63:0]        r_prod, n_prod;
    logic [31:0]               r_rem, n_rem;
    logic [31:0]               r_quo, n_quo;
    logic [31:0]               r_dvs, n_dvs;
    logic                      r_neg, n_neg;
    logic [4:0]                r_dcnt, n_dcnt;
    logic                      r_pend, n_pend;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    t_status                   r_err, n_err;
    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    t_status                   r_out_status, n_out_status;

    logic signed [VALUE_W-1:0] r_stack_mem [STACK_DEPTH];
    logic signed [VALUE_W-1:0] r_mem_q;
    logic                      w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]         w_rd_addr, w_wr_addr;

    logic                      w_accept, w_out_free;
    logic                      w_is_digit, w_is_oper, w_is_mul, w_is_div, w_is_sub;
    logic [SYM_W-1:0]          w_sym_off;
    logic [CNT_W-1:0]          w_cnt_dec;
    logic signed [VALUE_W:0]   w_sum;
    logic [31:0]               w_mag_a, w_mag_b;
    logic                      w_div_zero, w_div_big;
    logic [32:0]               w_div_sh, w_div_diff;
    logic                      w_div_ge;
    logic                      w_mul_fit;

    assign w_uop      = pfe_ucode(r_step);
    assign w_accept   = i_sym.valid && i_sym.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    assign i_sym.ready        = (w_uop.act == ACT_FETCH);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.status       = r_out_status;

    // Symbol decode on the latched character.
    assign w_is_digit = (r_sym >= SYM_ZERO) && (r_sym <= SYM_NINE);
    assign w_is_mul   = (r_sym == SYM_MUL);
    assign w_is_div   = (r_sym == SYM_DIV);
    assign w_is_sub   = (r_sym == SYM_MINUS);
    assign w_is_oper  = (r_sym == SYM_PLUS) || w_is_sub || w_is_mul || w_is_div;
    assign w_sym_off  = i_sym.symbol - SYM_ZERO;
    assign w_cnt_dec  = r_cnt - CNT_W'(1);

    assign w_sum = w_is_sub ? ({r_a[31], r_a} - {r_b[31], r_b})
                            : ({r_a[31], r_a} + {r_b[31], r_b});

    assign w_mag_a    = r_a[31] ? (~r_a + 32'd1) : r_a;
    assign w_mag_b    = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign w_div_zero = (r_b == '0);
    // The quotient reaches 2^32 exactly when the integer part of |a| is at
    // least |b|; such a result saturates whatever its sign.
    assign w_div_big  = ({16'h0000, w_mag_a[31:16]} >= w_mag_b);

    assign w_div_sh   = {r_rem, r_quo[31]};
    assign w_div_ge   = (w_div_sh >= {1'b0, r_dvs});
    assign w_div_diff = w_div_sh - {1'b0, r_dvs};

    // The product shifted right by 16 fits when bits 63 to 47 all agree.
    assign w_mul_fit = (&r_prod[63:47]) || !(|r_prod[63:47]);

    // Next step: microcode successor chosen by the selected condition.
    always_comb begin
        unique case (w_uop.cond)
            C_ALWAYS:  w_cond = 1'b1;
            C_ACCEPT:  w_cond = w_accept;
            C_DIGIT:   w_cond = w_is_digit;
            C_OPER:    w_cond = w_is_oper;
            C_DIV:     w_cond = w_is_div;
            C_MUL:     w_cond = w_is_mul;
            C_DIVSKIP: w_cond = w_div_zero || w_div_big;
            C_DIVLAST: w_cond = (r_dcnt == DIV_LAST);
            C_LAST:    w_cond = r_last;
            C_OUTFREE: w_cond = w_out_free;
            default:   w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_uop.nxt_t : w_uop.nxt_f;
    end

    // Datapath control decoded from the current control word.
    always_comb begin
        n_sym        = r_sym;
        n_last       = r_last;
        n_res        = r_res;
        n_a          = r_a;
        n_b          = r_b;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dvs        = r_dvs;
        n_neg        = r_neg;
        n_dcnt       = r_dcnt;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_rd_en      = 1'b0;
        w_rd_addr    = w_cnt_dec[ADDR_W-1:0];
        w_wr_en      = 1'b0;
        w_wr_addr    = r_cnt[ADDR_W-1:0];

        unique case (w_uop.act)
            ACT_FETCH: begin
                if (w_accept) begin
                    n_sym  = i_sym.symbol;
                    n_last = i_sym.is_last;
                    n_res  = $signed({12'h000, w_sym_off[3:0], 16'h0000});
                end
            end
            ACT_NONE: begin
            end
            ACT_POPR, ACT_POPL: begin
                if (w_uop.act == ACT_POPL) begin
                    n_b = r_pend ? r_mem_q : '0;
                end
                if (r_cnt == '0) begin
                    n_pend = 1'b0;
                    if (r_err == ST_OK) begin
                        n_err = ST_UNDER;
                    end
                end else begin
                    n_pend  = 1'b1;
                    n_cnt   = w_cnt_dec;
                    w_rd_en = 1'b1;
                end
            end
            ACT_LOADL: begin
                n_a = r_pend ? r_mem_q : '0;
            end
            ACT_ADDSUB: begin
                if (w_sum[32] != w_sum[31]) begin
                    n_res = w_sum[32] ? Q_MIN : Q_MAX;
                    if (r_err == ST_OK) begin
                        n_err = ST_SAT;
                    end
                end else begin
                    n_res = w_sum[31:0];
                end
            end
            ACT_MULP: begin
                n_prod = r_a * r_b;
            end
            ACT_MULF: begin
                // An arithmetic shift right rounds toward minus infinity.
                if (w_mul_fit) begin
                    n_res = r_prod[47:16];
                end else begin
                    n_res = r_prod[63] ? Q_MIN : Q_MAX;
                    if (r_err == ST_OK) begin
                        n_err = ST_SAT;
                    end
                end
            end
            ACT_DIVCHK: begin
                n_rem  = {16'h0000, w_mag_a[31:16]};
                n_quo  = {w_mag_a[15:0], 16'h0000};
                n_dvs  = w_mag_b;
                n_neg  = r_a[31] ^ r_b[31];
                n_dcnt = '0;
                if (w_div_zero) begin
                    n_res = r_a[31] ? Q_MIN : Q_MAX;
                    if (r_err == ST_OK) begin
                        n_err = ST_DIVZ;
                    end
                end else if (w_div_big) begin
                    n_res = (r_a[31] ^ r_b[31]) ? Q_MIN : Q_MAX;
                    if (r_err == ST_OK) begin
                        n_err = ST_SAT;
                    end
                end
            end
            ACT_DIVSTEP: begin
                n_rem  = w_div_ge ? w_div_diff[31:0] : w_div_sh[31:0];
                n_quo  = {r_quo[30:0], w_div_ge};
                n_dcnt = r_dcnt + 5'd1;
            end
            ACT_DIVFIN: begin
                if (r_neg) begin
                    if (r_quo > 32'h8000_0000) begin
                        n_res = Q_MIN;
                        if (r_err == ST_OK) begin
                            n_err = ST_SAT;
                        end
                    end else begin
                        n_res = $signed(~r_quo + 32'd1);
                    end
                end else if (r_quo[31]) begin
                    n_res = Q_MAX;
                    if (r_err == ST_OK) begin
                        n_err = ST_SAT;
                    end
                end else begin
                    n_res = $signed(r_quo);
                end
            end
            ACT_PUSH: begin
                if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_OVER;
                    end
                end else begin
                    w_wr_en = 1'b1;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
            end
            ACT_RDTOP: begin
                w_rd_en = r_last && (r_cnt != '0);
            end
            ACT_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = (r_cnt != '0) ? r_mem_q : '0;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                    end else if (r_cnt == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_status = ST_OK;
                    end
                    n_cnt = '0;
                    n_err = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // Operand stack: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack_mem[w_wr_addr] <= r_res;
        end
        if (w_rd_en) begin
            r_mem_q <= r_stack_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_dcnt      <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_res        <= n_res;
        r_a          <= n_a;
        r_b          <= n_b;
        r_prod       <= n_prod;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_dvs        <= n_dvs;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule
